// ===== hw/rtl/lmcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lmcr_pkg - shared types and constants for the capability rule table
// Request, action and status codes, rule layout and the word types of the
// request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package lmcr_pkg;

  // table geometry
  localparam int MAX_RULES = 256;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int HELD_W    = 9;
  localparam int TOTAL_W   = 32;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LEARNING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_ENABLE   = 1'd1;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // rule actions
  localparam logic [1:0] ACT_ALLOW   = 2'd0;
  localparam logic [1:0] ACT_DENY    = 2'd1;
  localparam logic [1:0] ACT_AUDIT   = 2'd2;
  localparam logic [1:0] ACT_SANDBOX = 2'd3;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NORELOAD = 2'd2;

  // controller states
  typedef enum logic {
    SC_IDLE,
    SC_SCAN
  } state_t;

  // request word
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  capability;
    logic [1:0]  rule_action;
    logic [31:0] subject_id;
    logic        rule_learning;
    logic [31:0] caller_pid;
  } in_word_t;

  // result word
  typedef struct packed {
    logic               allowed;
    logic [1:0]         status;
    logic [HELD_W-1:0]  rules_held;
    logic [TOTAL_W-1:0] rules_added_total;
  } out_word_t;

  // one stored rule, 39 bits
  typedef struct packed {
    logic [3:0]  cap;
    logic [1:0]  act;
    logic [31:0] target;
    logic        learn;
  } rule_t;

  // configuration registers as seen by the controller
  typedef struct packed {
    logic global_learning;
    logic reload_enable;
  } cfg_t;

  // rule store access from the controller
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rule_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lmcr_store.sv =====
// ----------------------------------------------------------------------------
// lmcr_store - rule memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcr_store (
  input  wire logic              clk,
  input  wire lmcr_pkg::mem_req_t mem_req,
  output lmcr_pkg::rule_t         rd_data
);
  import lmcr_pkg::*;

  rule_t mem [MAX_RULES];
  rule_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lmcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmcr_ctrl - request sequencer and newest-first rule scan
// Handles add, clear and check; a check walks the store one rule per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire lmcr_pkg::in_word_t   in_word,
  input  wire lmcr_pkg::cfg_t       cfg,
  output lmcr_pkg::mem_req_t        mem_req,
  input  wire lmcr_pkg::rule_t      rd_data,
  output logic                      out_strobe,
  output lmcr_pkg::out_word_t       out_word
);
  import lmcr_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] added_r, added_nxt;
  logic [IDX_W-1:0]   k_r;
  logic [3:0]         cap_r;
  logic [31:0]        pid_r;
  logic               out_strobe_r;
  out_word_t          out_word_r;

  logic             accept;
  logic             is_check;
  logic             have_rules;
  logic [CNT_W-1:0] cnt_m1;
  logic             room;
  logic [1:0]       status;
  logic             hit, decide, verdict, last, scan_done;

  assign accept     = start && (state_r == SC_IDLE);
  assign is_check   = (in_word.req_type == REQ_CHECK);
  assign have_rules = (count_r != '0);
  assign cnt_m1     = count_r - CNT_W'(1);
  assign room       = (count_r < CNT_W'(MAX_RULES));

  // rule evaluation on the word read out last cycle
  always_comb begin
    hit = (rd_data.cap == cap_r) &&
          ((rd_data.target == 32'd0) || (rd_data.target == pid_r));
    verdict = rd_data.learn || cfg.global_learning ||
              (rd_data.act == ACT_ALLOW) || (rd_data.act == ACT_SANDBOX);
    decide  = hit && (rd_data.learn || cfg.global_learning ||
                      (rd_data.act != ACT_AUDIT));
    last      = (k_r == '0);
    scan_done = (state_r == SC_SCAN) && (decide || last);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SC_IDLE: if (accept && is_check && have_rules) state_nxt = SC_SCAN;
      SC_SCAN: if (scan_done) state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  // outputs: handshake and memory access
  always_comb begin
    busy          = (state_r != SC_IDLE);
    mem_req.we    = 1'b0;
    mem_req.waddr = count_r[IDX_W-1:0];
    mem_req.wdata = '{cap:    in_word.capability,
                      act:    in_word.rule_action,
                      target: in_word.subject_id,
                      learn:  in_word.rule_learning};
    mem_req.re    = 1'b0;
    mem_req.raddr = cnt_m1[IDX_W-1:0];
    unique case (state_r)
      SC_IDLE: begin
        mem_req.we = accept && (in_word.req_type == REQ_ADD) && room;
        mem_req.re = accept && is_check && have_rules;
      end
      SC_SCAN: begin
        // reads never overlap a write: adds are taken only while idle
        mem_req.re    = !scan_done;
        mem_req.raddr = k_r - IDX_W'(1);
      end
      default: ;
    endcase
  end

  // counter updates and status for non-scan requests
  always_comb begin
    count_nxt = count_r;
    added_nxt = added_r;
    status    = ST_OK;
    if (accept) begin
      priority if (in_word.req_type == REQ_ADD) begin
        if (room) begin
          count_nxt = count_r + CNT_W'(1);
          added_nxt = added_r + TOTAL_W'(1);
        end else begin
          status = ST_FULL;
        end
      end else if (in_word.req_type == REQ_CLEAR) begin
        if (cfg.reload_enable) count_nxt = '0;
        else                   status    = ST_NORELOAD;
      end else begin
        status = ST_OK;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SC_IDLE;
      count_r      <= '0;
      added_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      added_r      <= added_nxt;
      out_strobe_r <= (accept && !(is_check && have_rules)) || scan_done;
    end
  end

  // scan pointer, captured request and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      k_r   <= cnt_m1[IDX_W-1:0];
      cap_r <= in_word.capability;
      pid_r <= in_word.caller_pid;
    end else if (state_r == SC_SCAN) begin
      k_r <= k_r - IDX_W'(1);
    end
    out_word_r.allowed           <= scan_done && decide && verdict;
    out_word_r.status            <= scan_done ? ST_OK : status;
    out_word_r.rules_held        <= HELD_W'(count_nxt);
    out_word_r.rules_added_total <= added_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

// ===== hw/rtl/last_match_capability_rule_table_top.sv =====
// ----------------------------------------------------------------------------
// last_match_capability_rule_table_top - capability rule table, last match wins
// Holds configuration registers and ties the sequencer to the rule memory.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  request | start, busy, in_word           | taken when start && !busy
//  result  | out_strobe, out_word           | one-cycle strobe, no backpressure
//  config  | cfg_valid, cfg_ready, cfg_index| written when valid && ready
//          | cfg_data                       |
//
// Add, clear and unused codes: result word in the cycle after acceptance, busy
// stays low, so such a word may follow every cycle.
// Check: busy while the scan runs (one stored rule per cycle through
// the memory read port), result in the cycle after the deciding rule; a check
// on an empty table answers in the cycle after acceptance.
// Reset is synchronous: counts zero, both config bits set, rule memory not
// cleared (entries at or above the count are never read).
// The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module last_match_capability_rule_table_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire lmcr_pkg::in_word_t                in_word,
  output logic                                   out_strobe,
  output lmcr_pkg::out_word_t                    out_word,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lmcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic                              cfg_data
);
  import lmcr_pkg::*;

  logic     global_learning_r;
  logic     reload_enable_r;
  cfg_t     cfg;
  mem_req_t mem_req;
  rule_t    rd_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_learning_r <= 1'b1;
      reload_enable_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GLOBAL_LEARNING: global_learning_r <= cfg_data;
        CFG_RELOAD_ENABLE:   reload_enable_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.global_learning = global_learning_r;
  assign cfg.reload_enable   = reload_enable_r;

  lmcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .cfg        (cfg),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  lmcr_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
